FILE: rtl/mm4_pkg.sv
// Package for the fixed-point 4x4 matrix multiplier: transaction codes, the
// sequencer state type, the control bundle for the MAC unit and the defaults.
// No dependencies.
package mm4_pkg;

  localparam int DIM_DEF  = 4;
  localparam int FRAC_DEF = 16;
  localparam int DATA_W   = 32;

  typedef enum logic [1:0] {
    KIND_LOAD_LEFT  = 2'd0,
    KIND_LOAD_RIGHT = 2'd1,
    KIND_COMPUTE    = 2'd2,
    KIND_UNUSED     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN
  } state_t;

  // Operand qualifier handed from the sequencer to the MAC unit.
  typedef struct packed {
    logic vld;
    logic first;
  } mac_ctl_t;

endpackage

FILE: rtl/mm4_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mm4_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/mm4_mac.sv
// Shared multiply-accumulate unit: registered 32x32 signed product, floor shift
// by the fraction width, wide accumulation and saturation to 32 bits.
// Depends on mm4_pkg.
module mm4_mac
  import mm4_pkg::*;
#(
  parameter int DIM       = DIM_DEF,
  parameter int FRAC_BITS = FRAC_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  mac_ctl_t                 ctl,
  input  logic signed [DATA_W-1:0] a,
  input  logic signed [DATA_W-1:0] b,
  output logic                     busy,
  output logic signed [DATA_W-1:0] result
);

  localparam int PROD_W = 2 * DATA_W;
  localparam int ACC_W  = PROD_W - FRAC_BITS + $clog2(DIM);

  localparam logic signed [ACC_W-1:0] SAT_MAX =
    ACC_W'(signed'({1'b0, {(DATA_W-1){1'b1}}}));
  localparam logic signed [ACC_W-1:0] SAT_MIN =
    ACC_W'(signed'({1'b1, {(DATA_W-1){1'b0}}}));

  logic                     prod_vld;
  logic                     prod_first;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] shifted;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld   <= 1'b0;
      prod_first <= 1'b0;
    end else begin
      prod_vld   <= ctl.vld;
      prod_first <= ctl.first;
    end
  end

  always_ff @(posedge clk) begin
    prod <= PROD_W'(a) * PROD_W'(b);
    if (prod_vld) begin
      acc <= prod_first ? term : acc + term;
    end
  end

  // Arithmetic shift rounds towards minus infinity.
  assign shifted = prod >>> FRAC_BITS;
  assign term    = ACC_W'(shifted);
  assign busy    = ctl.vld || prod_vld;

  always_comb begin
    if (acc > SAT_MAX) begin
      result = SAT_MAX[DATA_W-1:0];
    end else if (acc < SAT_MIN) begin
      result = SAT_MIN[DATA_W-1:0];
    end else begin
      result = acc[DATA_W-1:0];
    end
  end

endmodule

FILE: rtl/matrix4x4_multiply.sv
// Fixed-point DIM x DIM matrix multiplier on one shared MAC unit.
// Load transactions are taken while the sequencer is idle. For each product element
// a compute transaction issues DIM operand reads, passes them through the multiply and
// accumulate stages and hands the sum to the output register, which an output stall
// can hold up. Reset clears both matrices to zero through valid bits.
module matrix4x4_multiply
  import mm4_pkg::*;
#(
  parameter int DIM       = DIM_DEF,
  parameter int FRAC_BITS = FRAC_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               kind,
  input  logic [1:0]               row,
  input  logic [1:0]               col,
  input  logic signed [DATA_W-1:0] value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               out_row,
  output logic [1:0]               out_col,
  output logic signed [DATA_W-1:0] product,
  output logic                     last
);

  localparam int CELLS   = DIM * DIM;
  localparam int CELL_AW = $clog2(CELLS);
  localparam int IDX_W   = $clog2(DIM);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DIM - 1);

  // Sequencer: i walks product rows, k product columns, j the inner sum.
  state_t             state, state_next;
  logic [IDX_W-1:0]   i, i_next;
  logic [IDX_W-1:0]   k, k_next;
  logic [IDX_W-1:0]   j, j_next;
  logic               issue;
  logic               load_out;

  logic               accept;
  logic               in_range;
  logic               left_we;
  logic               right_we;
  logic [CELL_AW-1:0] waddr;
  logic [CELL_AW-1:0] left_raddr;
  logic [CELL_AW-1:0] right_raddr;
  logic [DATA_W-1:0]  left_rdata;
  logic [DATA_W-1:0]  right_rdata;

  // An entry that has never been written reads as zero, which is its reset value.
  logic [CELLS-1:0]   left_written;
  logic [CELLS-1:0]   right_written;
  logic               left_ok;
  logic               right_ok;

  logic               rd_vld;
  logic               rd_first;
  mac_ctl_t           mac_ctl;
  logic signed [DATA_W-1:0] op_a;
  logic signed [DATA_W-1:0] op_b;
  logic               mac_busy;
  logic signed [DATA_W-1:0] mac_result;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign in_range = (32'(row) < DIM) && (32'(col) < DIM);
  assign left_we  = accept && (kind == KIND_LOAD_LEFT) && in_range;
  assign right_we = accept && (kind == KIND_LOAD_RIGHT) && in_range;
  assign waddr    = CELL_AW'(32'(row) * DIM + 32'(col));

  assign left_raddr  = CELL_AW'(32'(i) * DIM + 32'(j));
  assign right_raddr = CELL_AW'(32'(j) * DIM + 32'(k));

  mm4_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CELLS)
  ) u_left_ram (
    .clk  (clk),
    .we   (left_we),
    .waddr(waddr),
    .wdata(value),
    .raddr(left_raddr),
    .rdata(left_rdata)
  );

  mm4_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CELLS)
  ) u_right_ram (
    .clk  (clk),
    .we   (right_we),
    .waddr(waddr),
    .wdata(value),
    .raddr(right_raddr),
    .rdata(right_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      left_written  <= '0;
      right_written <= '0;
    end else begin
      if (left_we) begin
        left_written[waddr] <= 1'b1;
      end
      if (right_we) begin
        right_written[waddr] <= 1'b1;
      end
    end
  end

  // The written flags are sampled alongside the RAM read so that they line up
  // with the registered read data.
  always_ff @(posedge clk) begin
    left_ok  <= left_written[left_raddr];
    right_ok <= right_written[right_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld   <= 1'b0;
      rd_first <= 1'b0;
    end else begin
      rd_vld   <= issue;
      rd_first <= issue && (j == '0);
    end
  end

  assign mac_ctl.vld   = rd_vld;
  assign mac_ctl.first = rd_first;
  assign op_a = left_ok  ? left_rdata  : '0;
  assign op_b = right_ok ? right_rdata : '0;

  mm4_mac #(
    .DIM      (DIM),
    .FRAC_BITS(FRAC_BITS)
  ) u_mac (
    .clk   (clk),
    .rst   (rst),
    .ctl   (mac_ctl),
    .a     (op_a),
    .b     (op_b),
    .busy  (mac_busy),
    .result(mac_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      i     <= '0;
      k     <= '0;
      j     <= '0;
    end else begin
      state <= state_next;
      i     <= i_next;
      k     <= k_next;
      j     <= j_next;
    end
  end

  // The sequencer issues DIM operand reads per element, waits for the MAC
  // pipeline to empty, then hands the saturated sum over once the output
  // register is free or being emptied in the same cycle.
  always_comb begin
    state_next = state;
    i_next     = i;
    k_next     = k;
    j_next     = j;
    issue      = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && (kind == KIND_COMPUTE)) begin
          state_next = ST_MAC;
          i_next     = '0;
          k_next     = '0;
          j_next     = '0;
        end
      end
      ST_MAC: begin
        issue = 1'b1;
        if (j == IDX_LAST) begin
          j_next     = '0;
          state_next = ST_DRAIN;
        end else begin
          j_next = j + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!mac_busy && (!out_valid || !out_stall)) begin
          load_out = 1'b1;
          if (k == IDX_LAST) begin
            k_next = '0;
            if (i == IDX_LAST) begin
              state_next = ST_IDLE;
            end else begin
              i_next     = i + 1'b1;
              state_next = ST_MAC;
            end
          end else begin
            k_next     = k + 1'b1;
            state_next = ST_MAC;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output register: the final element of a run may still wait here while
  // the block already takes the next load or compute transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_row <= 2'(i);
      out_col <= 2'(k);
      product <= mac_result;
      last    <= (i == IDX_LAST) && (k == IDX_LAST);
    end
  end

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !mac_busy)
    else $error("MAC pipeline still busy while the sequencer is idle");

  a_run_ends_on_last: assert property (@(posedge clk) disable iff (rst)
    ($past(state) == ST_DRAIN && state == ST_IDLE) |-> (out_valid && last))
    else $error("run finished without presenting its final element");

  a_inner_index_rest: assert property (@(posedge clk) disable iff (rst)
    (state != ST_MAC) |-> (j == '0))
    else $error("inner index not at rest outside the MAC phase");

  a_load_needs_free_out: assert property (@(posedge clk) disable iff (rst)
    load_out |-> (!out_valid || !out_stall))
    else $error("output register overwritten while stalled");

endmodule

FILE: verif/tb_matrix4x4_multiply.sv
// Self-checking testbench for the fixed-point 4x4 matrix multiplier: a queue-fed driver,
// a monitor and a Q16.16 product predictor that checks every element of every product run.
// Depends on mm4_pkg and on matrix4x4_multiply from the rtl folder.
module tb_matrix4x4_multiply
  import mm4_pkg::*;
();

  // The block is checked at its default size. With two-bit row and column fields and
  // DIM equal to four, an out-of-range load index cannot be expressed on the ports.
  localparam int MDIM       = DIM_DEF;
  localparam int FRAC       = FRAC_DEF;
  localparam int RAND_ITEMS = 310;
  localparam int HOLD_OFF   = 400;
  // Roughly 60 runs of 16 elements, each element waiting out a 57 per cent stall, plus
  // the long hold-off, stay far below this bound.
  localparam int CYCLE_LIMIT = 400000;

  // One input transaction as the driver offers it. When drain_first is set the
  // sender holds back until every expected product element has been delivered.
  typedef struct {
    kind_t       kind;
    logic [1:0]  row;
    logic [1:0]  col;
    logic [31:0] value;
    bit          drain_first;
  } xact_t;

  // One expected product element.
  typedef struct {
    logic [1:0]  row;
    logic [1:0]  col;
    logic [31:0] value;
    logic        last;
  } prod_elem_t;

  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     in_valid  = 1'b0;
  logic                     in_stall;
  kind_t                    kind      = KIND_LOAD_LEFT;
  logic [1:0]               row       = 2'd0;
  logic [1:0]               col       = 2'd0;
  logic signed [DATA_W-1:0] value     = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [1:0]               out_row;
  logic [1:0]               out_col;
  logic signed [DATA_W-1:0] product;
  logic                     last;

  // Stimulus waiting to be offered, and product elements waiting to arrive.
  xact_t      feed_q[$];
  prod_elem_t product_q[$];
  xact_t      drv_item;
  prod_elem_t got_elem;

  // The predictor's own copy of both matrices.
  logic signed [31:0] left_m [MDIM][MDIM];
  logic signed [31:0] right_m[MDIM][MDIM];

  int cycles        = 0;
  int items_taken   = 0;
  int ignored       = 0;
  int runs          = 0;
  int elems_checked = 0;
  int saturated     = 0;
  int errors        = 0;
  int held_in       = 0;
  int hold_left     = 0;
  bit hold_done     = 1'b0;
  bit in_taken      = 1'b0;

  matrix4x4_multiply u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .row       (row),
    .col       (col),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_row   (out_row),
    .out_col   (out_col),
    .product   (product),
    .last      (last)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
  end

  // Prints one line per mismatch and counts them all.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("[%0d] mismatch on %s: got %h, expected %h", cycles, what, got, want);
  endtask

  // Works out all sixteen elements of the product run that a compute transaction causes.
  // Each partial product is exact at 64 bits and floored by the arithmetic shift; the
  // sum stays wide and is only clamped to 32 bits at the end.
  task automatic queue_product_run();
    longint signed acc;
    longint signed term;
    prod_elem_t    e;
    for (int i = 0; i < MDIM; i++) begin
      for (int k = 0; k < MDIM; k++) begin
        acc = 0;
        for (int j = 0; j < MDIM; j++) begin
          term = longint'(left_m[i][j]) * longint'(right_m[j][k]);
          acc += term >>> FRAC;
        end
        if (acc > 64'sd2147483647) begin
          acc = 64'sd2147483647;
          saturated++;
        end else if (acc < -64'sd2147483648) begin
          acc = -64'sd2147483648;
          saturated++;
        end
        e.row   = i[1:0];
        e.col   = k[1:0];
        e.value = acc[31:0];
        e.last  = (i == MDIM - 1) && (k == MDIM - 1);
        product_q.push_back(e);
      end
    end
  endtask

  // Applies one accepted transaction to the predictor's state.
  task automatic absorb_item(input kind_t k, input logic [1:0] r, input logic [1:0] c,
                             input logic [31:0] v);
    case (k)
      KIND_LOAD_LEFT: begin
        left_m[r][c] = v;
      end
      KIND_LOAD_RIGHT: begin
        right_m[r][c] = v;
      end
      KIND_COMPUTE: begin
        runs++;
        queue_product_run();
      end
      default: begin
        ignored++;
      end
    endcase
  endtask

  // Idling plan: the sender idles lightly and the receiver heavily for the first third,
  // the other way round for the second, and neither idles for the rest.
  function automatic int idle_pct(input bit sender);
    if (items_taken < 110) begin
      return sender ? 22 : 57;
    end else if (items_taken < 220) begin
      return sender ? 57 : 22;
    end
    return 0;
  endfunction

  function automatic logic [31:0] rand_value();
    logic [31:0] v;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          2: v = 32'hFFFF_FFFF;
          default: v = 32'h0000_0000;
        endcase
      end
      1, 2: v = $urandom;
      3: begin
        // Large magnitudes, which tend to push sums past the 32-bit bounds.
        v = $urandom_range(32'h4000_0000, 32'h0100_0000);
        if ($urandom_range(1)) begin
          v = -v;
        end
      end
      default: begin
        // Modest Q16.16 values between about minus eight and plus eight.
        v = $urandom_range(32'h0010_0000) - 32'h0008_0000;
      end
    endcase
    return v;
  endfunction

  task automatic push_item(input kind_t k, input logic [1:0] r, input logic [1:0] c,
                           input logic [31:0] v, input bit drain);
    xact_t x;
    x.kind        = k;
    x.row         = r;
    x.col         = c;
    x.value       = v;
    x.drain_first = drain;
    feed_q.push_back(x);
  endtask

  // Directed opening: a product of empty matrices, unused transaction codes, both
  // saturation directions, a floored negative partial product, the extreme indices
  // and compute transactions whose row, column and value must be ignored.
  task automatic build_directed();
    push_item(KIND_COMPUTE,    2'd3, 2'd3, 32'hFFFF_FFFF, 1'b0);
    push_item(KIND_UNUSED,     2'd2, 2'd1, 32'h7FFF_FFFF, 1'b0);
    push_item(KIND_LOAD_LEFT,  2'd0, 2'd0, 32'h7FFF_FFFF, 1'b0);
    push_item(KIND_LOAD_LEFT,  2'd0, 2'd1, 32'h7FFF_FFFF, 1'b0);
    push_item(KIND_LOAD_RIGHT, 2'd0, 2'd0, 32'h7FFF_FFFF, 1'b0);
    push_item(KIND_LOAD_RIGHT, 2'd1, 2'd0, 32'h7FFF_FFFF, 1'b0);
    push_item(KIND_LOAD_LEFT,  2'd1, 2'd0, 32'h8000_0000, 1'b0);
    push_item(KIND_LOAD_LEFT,  2'd1, 2'd1, 32'h8000_0000, 1'b0);
    push_item(KIND_LOAD_RIGHT, 2'd0, 2'd1, 32'h7FFF_FFFF, 1'b0);
    push_item(KIND_LOAD_RIGHT, 2'd1, 2'd1, 32'h7FFF_FFFF, 1'b0);
    push_item(KIND_LOAD_LEFT,  2'd2, 2'd2, 32'hFFFF_FFFF, 1'b0);
    push_item(KIND_LOAD_RIGHT, 2'd2, 2'd2, 32'h0000_0001, 1'b0);
    push_item(KIND_LOAD_LEFT,  2'd3, 2'd3, 32'h8000_0000, 1'b0);
    push_item(KIND_LOAD_RIGHT, 2'd3, 2'd3, 32'h8000_0000, 1'b0);
    push_item(KIND_LOAD_LEFT,  2'd3, 2'd0, 32'h0001_0000, 1'b0);
    push_item(KIND_LOAD_RIGHT, 2'd0, 2'd3, 32'hFFFF_0000, 1'b0);
    push_item(KIND_COMPUTE,    2'd0, 2'd0, 32'h0000_0000, 1'b0);
    push_item(KIND_UNUSED,     2'd1, 2'd3, 32'h8000_0000, 1'b0);
    push_item(KIND_LOAD_RIGHT, 2'd3, 2'd3, 32'h0000_0000, 1'b0);
    push_item(KIND_COMPUTE,    2'd2, 2'd1, 32'h5555_5555, 1'b1);
  endtask

  // Random part: mostly well-formed runs (some loads with random content, then a
  // compute), now and then a full reload of both matrices, and the rest single
  // transactions of any kind. Unused codes do not count towards the total.
  task automatic build_random();
    int  counted;
    int  n_loads;
    bit  full;
    bit  drain;
    counted = 0;
    drain   = 1'b1;
    while (counted < RAND_ITEMS) begin
      if ($urandom_range(99) < 70) begin
        full    = ($urandom_range(9) == 0);
        n_loads = full ? 2 * MDIM * MDIM : $urandom_range(12, 1);
        for (int n = 0; n < n_loads; n++) begin
          if (full) begin
            push_item(n < MDIM * MDIM ? KIND_LOAD_LEFT : KIND_LOAD_RIGHT,
                      2'((n % (MDIM * MDIM)) / MDIM), 2'(n % MDIM), rand_value(), drain);
          end else begin
            push_item($urandom_range(1) ? KIND_LOAD_RIGHT : KIND_LOAD_LEFT,
                      2'($urandom_range(3)), 2'($urandom_range(3)), rand_value(), drain);
          end
          drain = 1'b0;
        end
        push_item(KIND_COMPUTE, 2'($urandom_range(3)), 2'($urandom_range(3)), $urandom,
                  1'b0);
        counted += n_loads + 1;
        drain = ($urandom_range(9) == 0);
      end else begin
        push_item(kind_t'($urandom_range(3)), 2'($urandom_range(3)),
                  2'($urandom_range(3)), rand_value(), drain);
        drain = 1'b0;
        if (feed_q[$].kind != KIND_UNUSED) begin
          counted++;
        end
      end
    end
  endtask

  // Records each accepted input transaction and hands it to the predictor. The flag
  // tells the driver that its slot is free again.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      in_taken = 1'b1;
      items_taken++;
      absorb_item(kind, row, col, value);
    end
    if (!rst && hold_left > 0 && in_valid && in_stall) begin
      held_in++;
    end
  end

  // Driver: changes the payload only at the falling edge, and only once the previous
  // transaction has gone or nothing was being offered, so a stalled payload holds.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      in_taken = 1'b0;
      if (feed_q.size() == 0 || $urandom_range(99) < idle_pct(1'b1) ||
          (feed_q[0].drain_first && product_q.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        drv_item = feed_q.pop_front();
        kind     <= drv_item.kind;
        row      <= drv_item.row;
        col      <= drv_item.col;
        value    <= drv_item.value;
        in_valid <= 1'b1;
      end
    end
  end

  // Receiver: random stalls per the idling plan, plus one long hold-off in the final
  // third, started in the middle of a product run while a transaction is waiting at
  // the input. With the sender still offering, the block has to back up and stall its
  // input for the whole stretch.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && items_taken >= 235 && in_valid && in_stall) begin
      hold_done = 1'b1;
      hold_left = HOLD_OFF;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < idle_pct(1'b0));
    end
  end

  // Monitor: every delivered element is compared, field by field, with the oldest
  // expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (product_q.size() == 0) begin
        report_mismatch("element with nothing expected", product, 32'h0);
      end else begin
        got_elem = product_q.pop_front();
        elems_checked++;
        if (out_row !== got_elem.row) begin
          report_mismatch("out_row", 32'(out_row), 32'(got_elem.row));
        end
        if (out_col !== got_elem.col) begin
          report_mismatch("out_col", 32'(out_col), 32'(got_elem.col));
        end
        if (product !== got_elem.value) begin
          report_mismatch("product", product, got_elem.value);
        end
        if (last !== got_elem.last) begin
          report_mismatch("last", 32'(last), 32'(got_elem.last));
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
    end
    $display("timeout after %0d cycles, %0d product elements outstanding",
             cycles, product_q.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    for (int i = 0; i < MDIM; i++) begin
      for (int j = 0; j < MDIM; j++) begin
        left_m[i][j]  = '0;
        right_m[i][j] = '0;
      end
    end
    build_directed();
    build_random();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Wait for the last transaction to be taken and every element to arrive, then
    // keep running so that any stray output from the block would show.
    while (feed_q.size() != 0 || in_valid) begin
      @(posedge clk);
    end
    while (product_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (150) @(posedge clk);

    $display("%0d transactions taken (%0d product runs, %0d unused codes ignored)",
             items_taken, runs, ignored);
    $display("%0d product elements checked, %0d saturated; input held off %0d cycles",
             elems_checked, saturated, held_in);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: matrix4x4_multiply.f
rtl/mm4_pkg.sv
rtl/mm4_ram.sv
rtl/mm4_mac.sv
rtl/matrix4x4_multiply.sv
verif/tb_matrix4x4_multiply.sv
